// ===== sv/swt_pkg.sv =====
package swt_pkg;

   // Queue between the classifier and the tokenizer state machine.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CHAR_W      = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   // Bit positions inside the response tdata.
   localparam int RSP_WORD_END_BIT = 8;
   localparam int RSP_REJECT_BIT   = 9;

   // Character codes with a meaning to the tokenizer.
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;
   localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_BTICK  = 8'h60;
   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_VTAB   = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FFEED  = 8'h0C;

   // Character class as seen by the state machine.
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_SQUOTE,
      CLS_DQUOTE,
      CLS_BSLASH,
      CLS_BLANK
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic           plain_ctrl;  // control syntax outside quotes
      logic           dq_special;  // rejected inside double quotes
   } class_info_type;

   // One queued request after classification.
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              is_final;
      class_info_type    info;
   } queue_entry_type;

endpackage

// ===== sv/swt_front.sv =====
module swt_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [swt_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] char_code
   input  logic                              req_tlast,   // is_final
   output logic                              push_valid,
   input  logic                              push_ready,
   output swt_pkg::queue_entry_type          push_data
);
   import swt_pkg::*;

   class_info_type info;
   logic [CHAR_W-1:0] ch;

   // Classify the incoming character; the queue absorbs the request directly.
   always_comb begin
      ch              = req_tdata[CHAR_W-1:0];
      info.cls        = CLS_OTHER;
      info.plain_ctrl = 1'b0;
      info.dq_special = 1'b0;
      if (ch == CH_SQUOTE) begin
         info.cls = CLS_SQUOTE;
      end else if (ch == CH_DQUOTE) begin
         info.cls = CLS_DQUOTE;
      end else if (ch == CH_BSLASH) begin
         info.cls = CLS_BSLASH;
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_VTAB ||
                   ch == CH_FFEED || ch == CH_CR) begin
         info.cls = CLS_BLANK;
      end
      info.plain_ctrl = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_PIPE) ||
                        (ch == CH_AMP) || (ch == CH_SEMI) || (ch == CH_LT) ||
                        (ch == CH_GT) || (ch == CH_BTICK) || (ch == CH_DOLLAR) ||
                        (ch == CH_STAR) || (ch == CH_QMARK) || (ch == CH_LBRACK) ||
                        (ch == CH_RBRACK) || (ch == CH_LBRACE) || (ch == CH_RBRACE) ||
                        (ch == CH_TILDE) || (ch == CH_LPAREN) || (ch == CH_RPAREN);
      info.dq_special = (ch == CH_BTICK) || (ch == CH_DOLLAR);
   end

   assign push_valid          = req_tvalid;
   assign req_tready          = push_ready;
   assign push_data.char_code = ch;
   assign push_data.is_final  = req_tlast;
   assign push_data.info      = info;

endmodule

// ===== sv/swt_queue.sv =====
module swt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  swt_pkg::queue_entry_type   push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output swt_pkg::queue_entry_type   pop_data
);
   import swt_pkg::*;

   queue_entry_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                        push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/swt_back.sv =====
module swt_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  swt_pkg::queue_entry_type        pop_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import swt_pkg::*;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_SINGLE,
      MODE_DOUBLE
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic              escape_ff, escape_in;
   logic              in_word_ff, in_word_in;
   logic              reject_ff, reject_in;

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] word_char_ff, word_char_in;
   logic              char_valid_ff, char_valid_in;
   logic              word_end_ff, word_end_in;
   logic              cmd_end_ff, cmd_end_in;
   logic              rsp_reject_ff, rsp_reject_in;

   logic              step;
   class_info_type    info;

   // A new request is taken whenever the output register is free or draining.
   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign step      = pop_valid && pop_ready;
   assign info      = pop_data.info;

   // Tokenizer state update for one character.
   always_comb begin
      mode_in       = mode_ff;
      escape_in     = escape_ff;
      in_word_in    = in_word_ff;
      reject_in     = reject_ff;
      char_valid_in = 1'b0;
      word_end_in   = 1'b0;
      rsp_reject_in = 1'b0;
      if (escape_ff) begin
         escape_in     = 1'b0;
         in_word_in    = 1'b1;
         char_valid_in = 1'b1;
      end else begin
         case (mode_ff)
            MODE_PLAIN: begin
               if (info.plain_ctrl) begin
                  reject_in = 1'b1;
               end
               case (info.cls)
                  CLS_SQUOTE: begin
                     in_word_in = 1'b1;
                     mode_in    = MODE_SINGLE;
                  end
                  CLS_DQUOTE: begin
                     in_word_in = 1'b1;
                     mode_in    = MODE_DOUBLE;
                  end
                  CLS_BSLASH: begin
                     in_word_in = 1'b1;
                     escape_in  = 1'b1;
                  end
                  CLS_BLANK: begin
                     if (in_word_ff) begin
                        word_end_in = 1'b1;
                        in_word_in  = 1'b0;
                     end
                  end
                  default: begin
                     in_word_in    = 1'b1;
                     char_valid_in = 1'b1;
                  end
               endcase
            end
            MODE_SINGLE: begin
               if (info.cls == CLS_SQUOTE) begin
                  mode_in = MODE_PLAIN;
               end else begin
                  char_valid_in = 1'b1;
               end
            end
            default: begin
               // Double-quoted text; an unused mode code behaves the same way.
               if (info.cls == CLS_DQUOTE) begin
                  mode_in = MODE_PLAIN;
               end else if (info.cls == CLS_BSLASH) begin
                  escape_in = 1'b1;
               end else begin
                  if (info.dq_special) begin
                     reject_in = 1'b1;
                  end
                  char_valid_in = 1'b1;
               end
            end
         endcase
      end

      // End of command: final verdict, then back to the idle state.
      if (pop_data.is_final) begin
         if (escape_in || mode_in != MODE_PLAIN) begin
            reject_in = 1'b1;
         end
         if (in_word_in) begin
            word_end_in = 1'b1;
         end
         rsp_reject_in = reject_in;
         mode_in       = MODE_PLAIN;
         escape_in     = 1'b0;
         in_word_in    = 1'b0;
         reject_in     = 1'b0;
      end

      cmd_end_in   = pop_data.is_final;
      word_char_in = char_valid_in ? pop_data.char_code : '0;
   end

   // Control state and the response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         escape_ff    <= 1'b0;
         in_word_ff   <= 1'b0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            mode_ff    <= mode_in;
            escape_ff  <= escape_in;
            in_word_ff <= in_word_in;
            reject_ff  <= reject_in;
         end
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (step) begin
         word_char_ff  <= word_char_in;
         char_valid_ff <= char_valid_in;
         word_end_ff   <= word_end_in;
         cmd_end_ff    <= cmd_end_in;
         rsp_reject_ff <= rsp_reject_in;
      end
   end

   always_comb begin
      rsp_tdata                   = '0;
      rsp_tdata[CHAR_W-1:0]       = word_char_ff;
      rsp_tdata[RSP_WORD_END_BIT] = word_end_ff;
      rsp_tdata[RSP_REJECT_BIT]   = rsp_reject_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = char_valid_ff;
   assign rsp_tlast  = cmd_end_ff;

endmodule

// ===== sv/shell_word_tokenizer_core.sv =====
// Shell word tokenizer: takes a command one byte per request, the last byte marked
// by req_tlast, and returns one response per byte carrying at most one word character
// (valid when rsp_tuser is high), a word-end flag, and on the response with rsp_tlast
// high the reject verdict for the whole command. It sustains one byte per clock cycle
// while rsp_tready stays high. A request accepted by the classifier is stored in the
// classifier queue, then moves into the tokenizer's output register, from which its
// response is taken. While the response side stalls, the block holds up to three
// requests (two in the queue, one in the output register) before it drops req_tready.
module shell_word_tokenizer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swt_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] char_code
   input  logic                            req_tlast,   // is_final
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swt_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] word_char, [8] word_end,
                                                         // [9] reject, [15:10] zero
   output logic                            rsp_tuser,   // char_valid
   output logic                            rsp_tlast    // command_end
);
   import swt_pkg::*;

   logic            push_valid, push_ready;
   queue_entry_type push_data;
   logic            pop_valid, pop_ready;
   queue_entry_type pop_data;

   swt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   swt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   swt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/swt_checker.sv =====
module swt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [swt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import swt_pkg::*;

   // A stalled response keeps its whole content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // The reject verdict is only given at the end of a command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_REJECT_BIT] |-> rsp_tlast)
      else $error("reject outside command end");

   // A response without a word character carries a zero character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[CHAR_W-1:0] == '0)
      else $error("word character without its valid flag");

   // Nothing is presented right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The empty block takes requests right after reset.
   assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

endmodule

bind shell_word_tokenizer_core swt_checker u_swt_checker (.*);
